@@ rtl/timezone_datetime_shift_core_defines.svh @@
// shared assertion macros for the zone shift core
`ifndef TIMEZONE_DATETIME_SHIFT_CORE_DEFINES_SVH
`define TIMEZONE_DATETIME_SHIFT_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define TZS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tzs: same-cycle check failed");

// next-cycle implication, held off during reset
`define TZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tzs: next-cycle check failed");

`endif

@@ rtl/tzs_pkg.sv @@
`default_nettype none

package tzs_pkg;

    // field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WEEK_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ZONE_W  = 12;

    // divide by 100 as multiply by 1311 / 2^17, exact for values below 4096
    localparam int             RECIP_W     = 23;
    localparam int             RECIP_SHIFT = 17;
    localparam logic [10:0]    RECIP_100   = 11'd1311;
    localparam logic [11:0]    ZONE_MAX    = 12'd1459;

    // direction of the day carry out of the time-of-day stage
    typedef enum logic [1:0] {
        CARRY_NONE,
        CARRY_FWD,
        CARRY_BACK
    } t_carry;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WEEK_W-1:0]  week;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_stamp;

    // zone split into sign, magnitude and hundreds
    typedef struct packed {
        logic        neg;
        logic [11:0] mag;
        logic [4:0]  quo;
    } t_zone_pre;

    // decoded zone, hour and minute in two's complement
    typedef struct packed {
        logic       ok;
        logic [5:0] hour;
        logic [6:0] minute;
    } t_zone;

    // normalized zone difference, dh and dm in two's complement
    typedef struct packed {
        logic       en;
        logic [5:0] dh;
        logic [6:0] dm;
        logic       leap;
    } t_shift;

    // calendar carry request
    typedef struct packed {
        t_carry dir;
        logic   en;
        logic   leap;
    } t_roll;

    localparam t_zone_pre ZONE_PRE_ZERO = '{neg: 1'b0, mag: 12'd0, quo: 5'd0};
    localparam t_zone     ZONE_ZERO     = '{ok: 1'b1, hour: 6'd0, minute: 7'd0};

    // quotient by 100 through the reciprocal
    function automatic logic [5:0] div100(input logic [11:0] v);
        logic [RECIP_W-1:0] prod;
        prod = RECIP_W'(v) * RECIP_W'(RECIP_100);
        return prod[RECIP_SHIFT +: 6];
    endfunction

    // first half of zone decode: magnitude and hundreds digit
    function automatic t_zone_pre zone_split(input logic [ZONE_W-1:0] z);
        t_zone_pre p;
        logic [5:0] q;
        p.neg = z[ZONE_W-1];
        p.mag = z[ZONE_W-1] ? (~z + 12'd1) : z;
        q     = div100(p.mag);
        p.quo = q[4:0];
        return p;
    endfunction

    // second half of zone decode: minutes digit, validity, signs
    function automatic t_zone zone_finish(input t_zone_pre p);
        t_zone      zn;
        logic [11:0] rem;
        logic [5:0]  hr;
        logic [6:0]  mn;
        rem       = p.mag - 12'(p.quo) * 12'd100;
        hr        = {1'b0, p.quo};
        mn        = rem[6:0];
        zn.ok     = (p.mag <= ZONE_MAX) && (rem <= 12'd59);
        zn.hour   = p.neg ? (~hr + 6'd1) : hr;
        zn.minute = p.neg ? (~mn + 7'd1) : mn;
        return zn;
    endfunction

    // month length, out-of-range months count 31 days
    function automatic logic [DAY_W-1:0] days_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tzs_offset.sv @@
`default_nettype none
`include "timezone_datetime_shift_core_defines.svh"

module tzs_offset (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire tzs_pkg::t_stamp i_stamp,
    input  wire [11:0]           i_source_zone,
    input  wire tzs_pkg::t_zone  i_local,
    output logic                 o_valid,
    input  wire                  i_ready,
    output tzs_pkg::t_stamp      o_stamp,
    output tzs_pkg::t_shift      o_shift
);

    // stage a: zone magnitude and hundreds, year hundreds
    logic               r_va;
    tzs_pkg::t_stamp    r_a_stamp;
    tzs_pkg::t_zone_pre r_a_src;
    logic [5:0]         r_a_yq;
    tzs_pkg::t_zone_pre n_a_src;
    logic [5:0]         n_a_yq;

    // stage b: raw hour and minute difference, leap flag
    logic               r_vb;
    tzs_pkg::t_stamp    r_b_stamp;
    logic [6:0]         r_b_dh;
    logic [7:0]         r_b_dm;
    logic               r_b_ok;
    logic               r_b_leap;
    tzs_pkg::t_zone     n_b_src;
    logic [6:0]         n_b_dh;
    logic [7:0]         n_b_dm;
    logic               n_b_ok;
    logic               n_b_leap;
    logic [11:0]        year_rem;

    // stage c: difference truncated toward zero
    logic               r_vc;
    tzs_pkg::t_stamp    r_c_stamp;
    tzs_pkg::t_shift    r_c_shift;
    tzs_pkg::t_shift    n_c_shift;
    logic signed [6:0]  h_norm;
    logic signed [7:0]  m_norm;

    logic rdy_a, rdy_b, rdy_c;

    // per-stage ready, a stage loads when empty or draining
    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // stage a logic
    always_comb begin
        n_a_src = tzs_pkg::zone_split(i_source_zone);
        n_a_yq  = tzs_pkg::div100(i_stamp.year);
    end

    // stage b logic
    always_comb begin
        n_b_src  = tzs_pkg::zone_finish(r_a_src);
        n_b_dh   = {i_local.hour[5], i_local.hour} - {n_b_src.hour[5], n_b_src.hour};
        n_b_dm   = {i_local.minute[6], i_local.minute}
                 - {n_b_src.minute[6], n_b_src.minute};
        n_b_ok   = i_local.ok && n_b_src.ok;
        year_rem = r_a_stamp.year - 12'(r_a_yq) * 12'd100;
        n_b_leap = (r_a_stamp.year[1:0] == 2'd0)
                && ((year_rem != 12'd0) || (r_a_yq[1:0] == 2'd0));
    end

    // stage c logic: fold minutes into hours, then match signs
    always_comb begin
        h_norm = $signed(r_b_dh);
        m_norm = $signed(r_b_dm);
        if (m_norm >= 8'sd60) begin
            m_norm = m_norm - 8'sd60;
            h_norm = h_norm + 7'sd1;
        end else if (m_norm <= -8'sd60) begin
            m_norm = m_norm + 8'sd60;
            h_norm = h_norm - 7'sd1;
        end
        if ((h_norm > 7'sd0) && (m_norm < 8'sd0)) begin
            m_norm = m_norm + 8'sd60;
            h_norm = h_norm - 7'sd1;
        end else if ((h_norm < 7'sd0) && (m_norm > 8'sd0)) begin
            m_norm = m_norm - 8'sd60;
            h_norm = h_norm + 7'sd1;
        end
        n_c_shift.en   = r_b_ok && (h_norm > -7'sd24) && (h_norm < 7'sd24);
        n_c_shift.dh   = h_norm[5:0];
        n_c_shift.dm   = m_norm[6:0];
        n_c_shift.leap = r_b_leap;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && rdy_a) begin
            r_a_stamp <= i_stamp;
            r_a_src   <= n_a_src;
            r_a_yq    <= n_a_yq;
        end
        if (r_va && rdy_b) begin
            r_b_stamp <= r_a_stamp;
            r_b_dh    <= n_b_dh;
            r_b_dm    <= n_b_dm;
            r_b_ok    <= n_b_ok;
            r_b_leap  <= n_b_leap;
        end
        if (r_vb && rdy_c) begin
            r_c_stamp <= r_b_stamp;
            r_c_shift <= n_c_shift;
        end
    end

    assign o_valid = r_vc;
    assign o_stamp = r_c_stamp;
    assign o_shift = r_c_shift;

    // an applied shift has minutes under an hour and the same sign as hours
    `TZS_ASSERT_NOW(a_shift_norm, i_clk, i_rst_n, r_vc && r_c_shift.en, ($signed(r_c_shift.dm) < 7'sd60) && ($signed(r_c_shift.dm) > -7'sd60) && ((r_c_shift.dh == 6'd0) || (r_c_shift.dm == 7'd0) || (r_c_shift.dh[5] == r_c_shift.dm[6])))

endmodule

`default_nettype wire

@@ rtl/tzs_clock.sv @@
`default_nettype none
`include "timezone_datetime_shift_core_defines.svh"

module tzs_clock (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire tzs_pkg::t_stamp i_stamp,
    input  wire tzs_pkg::t_shift i_shift,
    output logic                 o_valid,
    input  wire                  i_ready,
    output tzs_pkg::t_stamp      o_stamp,
    output tzs_pkg::t_roll       o_roll
);

    logic              r_valid;
    tzs_pkg::t_stamp   r_stamp;
    tzs_pkg::t_roll    r_roll;
    tzs_pkg::t_stamp   n_stamp;
    tzs_pkg::t_roll    n_roll;

    logic signed [7:0] min_sum;
    logic signed [7:0] min_adj;
    logic signed [6:0] hour_carry;
    logic signed [6:0] hour_sum;
    logic signed [6:0] hour_adj;
    tzs_pkg::t_carry   dir;

    assign o_ready = !r_valid || i_ready;

    // minute add with one correction, then hour add with one correction
    always_comb begin
        min_sum    = $signed({2'b00, i_stamp.minute}) + $signed({i_shift.dm[6], i_shift.dm});
        min_adj    = min_sum;
        hour_carry = 7'sd0;
        if (min_sum > 8'sd59) begin
            min_adj    = min_sum - 8'sd60;
            hour_carry = 7'sd1;
        end else if (min_sum < 8'sd0) begin
            min_adj    = min_sum + 8'sd60;
            hour_carry = -7'sd1;
        end
        hour_sum = $signed({2'b00, i_stamp.hour}) + $signed({i_shift.dh[5], i_shift.dh})
                 + hour_carry;
        hour_adj = hour_sum;
        dir      = tzs_pkg::CARRY_NONE;
        if (hour_sum > 7'sd23) begin
            hour_adj = hour_sum - 7'sd24;
            dir      = tzs_pkg::CARRY_FWD;
        end else if (hour_sum < 7'sd0) begin
            hour_adj = hour_sum + 7'sd24;
            dir      = tzs_pkg::CARRY_BACK;
        end

        n_stamp = i_stamp;
        if (i_shift.en) begin
            n_stamp.minute = min_adj[5:0];
            n_stamp.hour   = hour_adj[4:0];
        end
        n_roll.dir  = i_shift.en ? dir : tzs_pkg::CARRY_NONE;
        n_roll.en   = i_shift.en;
        n_roll.leap = i_shift.leap;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stamp <= n_stamp;
            r_roll  <= n_roll;
        end
    end

    assign o_valid = r_valid;
    assign o_stamp = r_stamp;
    assign o_roll  = r_roll;

    // an unapplied shift never requests a day carry
    `TZS_ASSERT_NEXT(a_off_no_carry, i_clk, i_rst_n, i_valid && o_ready && !i_shift.en, (r_roll.dir == tzs_pkg::CARRY_NONE) && !r_roll.en)
    // an unapplied shift leaves the time fields alone
    `TZS_ASSERT_NEXT(a_off_pass, i_clk, i_rst_n, i_valid && o_ready && !i_shift.en, r_stamp == $past(i_stamp))

endmodule

`default_nettype wire

@@ rtl/tzs_calendar.sv @@
`default_nettype none
`include "timezone_datetime_shift_core_defines.svh"

module tzs_calendar (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire tzs_pkg::t_stamp i_stamp,
    input  wire tzs_pkg::t_roll  i_roll,
    output logic                 o_valid,
    input  wire                  i_ready,
    output tzs_pkg::t_stamp      o_stamp,
    output logic                 o_adjusted
);

    logic            r_valid;
    tzs_pkg::t_stamp r_stamp;
    logic            r_adjusted;
    tzs_pkg::t_stamp n_stamp;

    logic [4:0]      len_cur;
    logic [4:0]      len_prev;
    logic [3:0]      prev_month;
    logic [5:0]      day_inc;
    logic [4:0]      month_inc;

    assign o_ready = !r_valid || i_ready;

    // one day forward or back with weekday, month and year carry, or no change
    always_comb begin
        len_cur    = tzs_pkg::days_len(i_stamp.month, i_roll.leap);
        prev_month = (i_stamp.month <= 4'd1) ? 4'd12 : (i_stamp.month - 4'd1);
        len_prev   = tzs_pkg::days_len(prev_month, i_roll.leap);
        day_inc    = {1'b0, i_stamp.day} + 6'd1;
        month_inc  = {1'b0, i_stamp.month} + 5'd1;
        n_stamp    = i_stamp;
        case (i_roll.dir)
            tzs_pkg::CARRY_FWD: begin
                n_stamp.week = (i_stamp.week >= 3'd6) ? 3'd0 : (i_stamp.week + 3'd1);
                if (day_inc > {1'b0, len_cur}) begin
                    n_stamp.day = 5'd1;
                    if (month_inc > 5'd12) begin
                        n_stamp.month = 4'd1;
                        n_stamp.year  = i_stamp.year + 12'd1;
                    end else begin
                        n_stamp.month = month_inc[3:0];
                    end
                end else begin
                    n_stamp.day = day_inc[4:0];
                end
            end
            tzs_pkg::CARRY_BACK: begin
                n_stamp.week = (i_stamp.week == 3'd0) ? 3'd6 : (i_stamp.week - 3'd1);
                if (i_stamp.day <= 5'd1) begin
                    n_stamp.month = prev_month;
                    if (i_stamp.month <= 4'd1) begin
                        n_stamp.year = i_stamp.year - 12'd1;
                    end
                    n_stamp.day = len_prev;
                end else begin
                    n_stamp.day = i_stamp.day - 5'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stamp    <= n_stamp;
            r_adjusted <= i_roll.en;
        end
    end

    assign o_valid    = r_valid;
    assign o_stamp    = r_stamp;
    assign o_adjusted = r_adjusted;

    // with no day carry the date fields come through untouched
    `TZS_ASSERT_NEXT(a_no_carry_date, i_clk, i_rst_n, i_valid && o_ready && (i_roll.dir == tzs_pkg::CARRY_NONE), (r_stamp.year == $past(i_stamp.year)) && (r_stamp.month == $past(i_stamp.month)) && (r_stamp.day == $past(i_stamp.day)) && (r_stamp.week == $past(i_stamp.week)))

endmodule

`default_nettype wire

@@ rtl/timezone_datetime_shift_core.sv @@
// Moves a real-time-clock time stamp from its own zone to the local zone held in the
// configuration register (signed hhmm). The zone difference is added to minute and hour with
// one carry or borrow into weekday, day, month and year under the Gregorian leap rule; seconds
// pass through. When either zone is invalid or the difference reaches a full day, the stamp
// passes unchanged with o_adjusted low. One request is taken per clock unless every stage is
// full and the output is stalled. Three stages decode the zones and the difference, one adds
// to the time of day, one carries into the calendar and holds the result. Each stage has its
// own valid bit and loads whenever it is empty or being drained, so requests keep flowing into
// empty stages while a result waits at the output. A local zone write is decoded in two steps
// and is in effect for requests that arrive after it.
`default_nettype none
`include "timezone_datetime_shift_core_defines.svh"

module timezone_datetime_shift_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // local zone write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [11:0] i_cfg_local_zone,
    // request
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [11:0] i_in_year,
    input  wire  [3:0]  i_in_month,
    input  wire  [4:0]  i_in_day,
    input  wire  [2:0]  i_in_weekday,
    input  wire  [4:0]  i_in_hour,
    input  wire  [5:0]  i_in_minute,
    input  wire  [5:0]  i_in_second,
    input  wire  [11:0] i_source_zone,
    // result
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [11:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [2:0]  o_out_weekday,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [5:0]  o_out_second,
    output logic        o_adjusted
);

    tzs_pkg::t_zone_pre r_loc_pre;
    tzs_pkg::t_zone     r_loc;

    tzs_pkg::t_stamp    in_stamp;
    tzs_pkg::t_stamp    off_stamp;
    tzs_pkg::t_shift    off_shift;
    logic               off_valid;
    logic               clk_ready;
    tzs_pkg::t_stamp    clk_stamp;
    tzs_pkg::t_roll     clk_roll;
    logic               clk_valid;
    logic               cal_ready;
    tzs_pkg::t_stamp    out_stamp;

    // local zone register, decoded in two steps
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_pre <= tzs_pkg::ZONE_PRE_ZERO;
            r_loc     <= tzs_pkg::ZONE_ZERO;
        end else begin
            if (i_cfg_valid) begin
                r_loc_pre <= tzs_pkg::zone_split(i_cfg_local_zone);
            end
            r_loc <= tzs_pkg::zone_finish(r_loc_pre);
        end
    end

    // request fields into one stamp
    always_comb begin
        in_stamp.year   = i_in_year;
        in_stamp.month  = i_in_month;
        in_stamp.day    = i_in_day;
        in_stamp.week   = i_in_weekday;
        in_stamp.hour   = i_in_hour;
        in_stamp.minute = i_in_minute;
        in_stamp.second = i_in_second;
    end

    tzs_offset u_offset (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_stamp       (in_stamp),
        .i_source_zone (i_source_zone),
        .i_local       (r_loc),
        .o_valid       (off_valid),
        .i_ready       (clk_ready),
        .o_stamp       (off_stamp),
        .o_shift       (off_shift)
    );

    tzs_clock u_clock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (off_valid),
        .o_ready (clk_ready),
        .i_stamp (off_stamp),
        .i_shift (off_shift),
        .o_valid (clk_valid),
        .i_ready (cal_ready),
        .o_stamp (clk_stamp),
        .o_roll  (clk_roll)
    );

    tzs_calendar u_calendar (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (clk_valid),
        .o_ready    (cal_ready),
        .i_stamp    (clk_stamp),
        .i_roll     (clk_roll),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_stamp    (out_stamp),
        .o_adjusted (o_adjusted)
    );

    // result fields
    assign o_out_year    = out_stamp.year;
    assign o_out_month   = out_stamp.month;
    assign o_out_day     = out_stamp.day;
    assign o_out_weekday = out_stamp.week;
    assign o_out_hour    = out_stamp.hour;
    assign o_out_minute  = out_stamp.minute;
    assign o_out_second  = out_stamp.second;

    // requests are refused only when every stage is full and the output is stalled
    `TZS_ASSERT_NOW(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready && off_valid && clk_valid)

endmodule

`default_nettype wire

@@ dv/timezone_datetime_shift_core_tb.sv @@
`timescale 1ns / 100ps

module timezone_datetime_shift_core_tb;

    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 240;

    // one request: clock time plus the zone it was read in
    typedef struct packed {
        tzs_pkg::t_stamp            stamp;
        logic [tzs_pkg::ZONE_W-1:0] zone;
    } t_req;

    // one result: shifted time plus the applied flag
    typedef struct packed {
        tzs_pkg::t_stamp stamp;
        logic            adjusted;
    } t_res;

    // directed row, result typed in only where known is set
    typedef struct {
        logic [tzs_pkg::ZONE_W-1:0] lz;
        t_req                       req;
        bit                         known;
        t_res                       res;
    } t_case;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic [tzs_pkg::ZONE_W-1:0] cfg_zone     = '0;
    logic                       in_valid     = 1'b0;
    t_req                       stamp_in     = '0;
    t_res                       stamp_expect = '0;
    logic                       out_ready    = 1'b0;

    wire               o_cfg_ready;
    wire               o_in_ready;
    wire               o_out_valid;
    wire  [11:0]       o_out_year;
    wire  [3:0]        o_out_month;
    wire  [4:0]        o_out_day;
    wire  [2:0]        o_out_weekday;
    wire  [4:0]        o_out_hour;
    wire  [5:0]        o_out_minute;
    wire  [5:0]        o_out_second;
    wire               o_adjusted;

    // local zone as the block should hold it
    logic [tzs_pkg::ZONE_W-1:0] zone_reg = '0;
    t_res              local_stamps_q[$];
    t_case             dir_cases[$];
    int                fail_cnt   = 0;
    int                stuck_cnt  = 0;
    bit                idle_on    = 1'b1;
    bit                hold_start = 1'b0;

    timezone_datetime_shift_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_local_zone (cfg_zone),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_year        (stamp_in.stamp.year),
        .i_in_month       (stamp_in.stamp.month),
        .i_in_day         (stamp_in.stamp.day),
        .i_in_weekday     (stamp_in.stamp.week),
        .i_in_hour        (stamp_in.stamp.hour),
        .i_in_minute      (stamp_in.stamp.minute),
        .i_in_second      (stamp_in.stamp.second),
        .i_source_zone    (stamp_in.zone),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_out_year       (o_out_year),
        .o_out_month      (o_out_month),
        .o_out_day        (o_out_day),
        .o_out_weekday    (o_out_weekday),
        .o_out_hour       (o_out_hour),
        .o_out_minute     (o_out_minute),
        .o_out_second     (o_out_second),
        .o_adjusted       (o_adjusted)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hhmm zone must stay within 14:59 with minutes below 60
    function automatic bit zone_valid(input int z);
        int m;
        m = (z < 0) ? -z : z;
        return (m <= 1459) && ((m % 100) <= 59);
    endfunction

    function automatic int zone_minutes(input int z);
        return (z / 100) * 60 + (z % 100);
    endfunction

    // gregorian month length, months outside 1..12 count 31
    function automatic int mon_len(input int mo, input int yr);
        bit leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mo)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // expected local time for one request under the given local zone
    function automatic t_res shift_stamp(input t_req r,
                                         input logic [tzs_pkg::ZONE_W-1:0] lz);
        t_res o;
        int   yr, mo, dy, wk, hr, mn, src, dst, diff;
        yr  = r.stamp.year;
        mo  = r.stamp.month;
        dy  = r.stamp.day;
        wk  = r.stamp.week;
        hr  = r.stamp.hour;
        mn  = r.stamp.minute;
        src = $signed(r.zone);
        dst = $signed(lz);
        o.adjusted = 1'b0;
        if (zone_valid(src) && zone_valid(dst)) begin
            diff = zone_minutes(dst) - zone_minutes(src);
            if (diff > -1440 && diff < 1440) begin
                o.adjusted = 1'b1;
                // minute part with a single carry or borrow into the hour
                mn += diff % 60;
                if (mn > 59) begin
                    mn -= 60;
                    hr++;
                end else if (mn < 0) begin
                    mn += 60;
                    hr--;
                end
                hr += diff / 60;
                // one day step forward or back through the calendar
                if (hr > 23) begin
                    hr -= 24;
                    wk = (wk >= 6) ? 0 : wk + 1;
                    dy++;
                    if (dy > mon_len(mo, yr)) begin
                        dy = 1;
                        mo++;
                        if (mo > 12) begin
                            mo = 1;
                            yr = (yr + 1) % 4096;
                        end
                    end
                end else if (hr < 0) begin
                    hr += 24;
                    wk = (wk == 0) ? 6 : wk - 1;
                    dy--;
                    if (dy < 1) begin
                        mo--;
                        if (mo < 1) begin
                            mo = 12;
                            yr = (yr + 4095) % 4096;
                        end
                        dy = mon_len(mo, yr);
                    end
                end
            end
        end
        o.stamp.year   = tzs_pkg::YEAR_W'(yr);
        o.stamp.month  = tzs_pkg::MONTH_W'(mo);
        o.stamp.day    = tzs_pkg::DAY_W'(dy);
        o.stamp.week   = tzs_pkg::WEEK_W'(wk);
        o.stamp.hour   = tzs_pkg::HOUR_W'(hr);
        o.stamp.minute = tzs_pkg::MIN_W'(mn);
        o.stamp.second = r.stamp.second;
        return o;
    endfunction

    function automatic tzs_pkg::t_stamp mk_stamp(input int y, input int mo, input int d,
                                                 input int w, input int h, input int mi,
                                                 input int s);
        tzs_pkg::t_stamp st;
        st.year   = tzs_pkg::YEAR_W'(y);
        st.month  = tzs_pkg::MONTH_W'(mo);
        st.day    = tzs_pkg::DAY_W'(d);
        st.week   = tzs_pkg::WEEK_W'(w);
        st.hour   = tzs_pkg::HOUR_W'(h);
        st.minute = tzs_pkg::MIN_W'(mi);
        st.second = tzs_pkg::SEC_W'(s);
        return st;
    endfunction

    // random valid hhmm zone, often on whole or half hours
    function automatic logic [tzs_pkg::ZONE_W-1:0] rand_zone();
        int h, m;
        h = $urandom_range(0, 14);
        case ($urandom_range(0, 3))
            0:       m = 0;
            1:       m = 30;
            default: m = $urandom_range(0, 59);
        endcase
        return $urandom_range(0, 1) ? tzs_pkg::ZONE_W'(-(h * 100 + m))
                                    : tzs_pkg::ZONE_W'(h * 100 + m);
    endfunction

    task automatic add_case(input int lz, input tzs_pkg::t_stamp st, input int src,
                            input bit known, input tzs_pkg::t_stamp rs, input bit adj);
        t_case c;
        c.lz        = tzs_pkg::ZONE_W'(lz);
        c.req.stamp = st;
        c.req.zone  = tzs_pkg::ZONE_W'(src);
        c.known     = known;
        c.res.stamp = rs;
        c.res.adjusted = adj;
        dir_cases.push_back(c);
    endtask

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_cnt++;
        end
    endtask

    // zone write only with nothing in flight
    task automatic load_zone(input logic [tzs_pkg::ZONE_W-1:0] z);
        in_valid <= 1'b0;
        while (local_stamps_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_zone  <= z;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        zone_reg = z;
    endtask

    // offer one request, optionally after a gap, and wait until it is taken
    task automatic offer_stamp(input t_req r, input t_res e);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        stamp_in     <= r;
        stamp_expect <= e;
        in_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random stall bursts plus one long hold-off on request
    initial begin : result_side
        int hold_left;
        int stall_left;
        bit rdy;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!idle_on) begin
                rdy = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // compare results, log accepted requests, watch for a hang
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (local_stamps_q.size() == 0) begin
                    $error("result arrived with no request pending");
                    fail_cnt++;
                end else begin
                    want = local_stamps_q.pop_front();
                    check_field("out_year", want.stamp.year, o_out_year);
                    check_field("out_month", want.stamp.month, o_out_month);
                    check_field("out_day", want.stamp.day, o_out_day);
                    check_field("out_weekday", want.stamp.week, o_out_weekday);
                    check_field("out_hour", want.stamp.hour, o_out_hour);
                    check_field("out_minute", want.stamp.minute, o_out_minute);
                    check_field("out_second", want.stamp.second, o_out_second);
                    check_field("adjusted", want.adjusted, o_adjusted);
                end
            end
            if (in_valid && o_in_ready)
                local_stamps_q.push_back(stamp_expect);
            if ((o_out_valid && out_ready) || (in_valid && o_in_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                stuck_cnt = 0;
            end else begin
                stuck_cnt++;
            end
            if (stuck_cnt >= STUCK_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_req                       req;
        logic [tzs_pkg::ZONE_W-1:0] lz;
        int                         yr, mo, len, kind;

        // reset value of the local zone, then bad source zones
        add_case(0, mk_stamp(2024, 2, 29, 4, 12, 34, 56), 0, 1'b1,
                 mk_stamp(2024, 2, 29, 4, 12, 34, 56), 1'b1);
        add_case(0, mk_stamp(2023, 7, 15, 6, 8, 0, 0), 1460, 1'b1,
                 mk_stamp(2023, 7, 15, 6, 8, 0, 0), 1'b0);
        add_case(0, mk_stamp(2023, 7, 15, 6, 8, 0, 0), -2048, 1'b1,
                 mk_stamp(2023, 7, 15, 6, 8, 0, 0), 1'b0);
        add_case(0, mk_stamp(1999, 1, 2, 1, 3, 4, 5), 160, 1'b1,
                 mk_stamp(1999, 1, 2, 1, 3, 4, 5), 1'b0);
        // full day of difference is refused, one minute less is applied
        add_case(1200, mk_stamp(2023, 12, 31, 0, 22, 10, 5), -1200, 1'b1,
                 mk_stamp(2023, 12, 31, 0, 22, 10, 5), 1'b0);
        add_case(1200, mk_stamp(2023, 12, 31, 0, 22, 10, 5), -1159, 1'b0, '0, 1'b0);
        // largest local zone: widest spread, year wrap forward, leap edges
        add_case(1459, mk_stamp(2023, 6, 1, 3, 1, 2, 3), -1459, 1'b1,
                 mk_stamp(2023, 6, 1, 3, 1, 2, 3), 1'b0);
        add_case(1459, mk_stamp(4095, 12, 31, 6, 23, 59, 59), -900, 1'b1,
                 mk_stamp(0, 1, 1, 0, 23, 58, 59), 1'b1);
        add_case(1459, mk_stamp(2023, 2, 28, 2, 10, 30, 0), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(2024, 2, 28, 3, 10, 30, 0), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(1900, 2, 28, 3, 10, 30, 0), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(2000, 2, 28, 1, 10, 30, 0), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(0, 2, 28, 1, 10, 30, 0), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(2023, 4, 30, 0, 20, 0, 0), 0, 1'b0, '0, 1'b0);
        // out-of-range fields going forward
        add_case(1459, mk_stamp(2023, 0, 31, 7, 23, 59, 63), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(2023, 14, 31, 5, 31, 63, 60), 0, 1'b0, '0, 1'b0);
        add_case(1459, mk_stamp(2023, 5, 0, 5, 15, 0, 0), 0, 1'b0, '0, 1'b0);
        // smallest local zone: year wrap back, borrows, out-of-range fields
        add_case(-1459, mk_stamp(0, 1, 1, 0, 0, 0, 0), 900, 1'b1,
                 mk_stamp(4095, 12, 31, 6, 0, 1, 0), 1'b1);
        add_case(-1459, mk_stamp(2024, 3, 1, 5, 5, 10, 20), 0, 1'b0, '0, 1'b0);
        add_case(-1459, mk_stamp(2100, 3, 1, 1, 5, 10, 20), 0, 1'b0, '0, 1'b0);
        add_case(-1459, mk_stamp(2023, 5, 0, 7, 3, 0, 0), 0, 1'b0, '0, 1'b0);
        add_case(-1459, mk_stamp(2023, 15, 1, 2, 2, 0, 0), 0, 1'b0, '0, 1'b0);
        add_case(-1459, mk_stamp(2023, 8, 8, 2, 31, 0, 61), 0, 1'b0, '0, 1'b0);
        // local zone just past the negative limit
        add_case(-1460, mk_stamp(2023, 9, 9, 6, 9, 9, 9), 0, 1'b1,
                 mk_stamp(2023, 9, 9, 6, 9, 9, 9), 1'b0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_cases[i]) begin
            if (dir_cases[i].lz != zone_reg)
                load_zone(dir_cases[i].lz);
            offer_stamp(dir_cases[i].req, dir_cases[i].known ? dir_cases[i].res :
                        shift_stamp(dir_cases[i].req, zone_reg));
        end

        // random phases, each under its own local zone
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lz = tzs_pkg::ZONE_W'(1459);
                1:       lz = tzs_pkg::ZONE_W'(-1459);
                2:       lz = tzs_pkg::ZONE_W'(-2048);
                3:       lz = tzs_pkg::ZONE_W'(2047);
                4:       lz = tzs_pkg::ZONE_W'(-530);
                default: lz = ($urandom_range(0, 3) == 0) ? tzs_pkg::ZONE_W'($urandom)
                                                          : rand_zone();
            endcase
            load_zone(lz);
            idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 1)
                hold_start = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    // noise across the full width of every field
                    req.stamp.year   = tzs_pkg::YEAR_W'($urandom);
                    req.stamp.month  = tzs_pkg::MONTH_W'($urandom);
                    req.stamp.day    = tzs_pkg::DAY_W'($urandom);
                    req.stamp.week   = tzs_pkg::WEEK_W'($urandom);
                    req.stamp.hour   = tzs_pkg::HOUR_W'($urandom);
                    req.stamp.minute = tzs_pkg::MIN_W'($urandom);
                    req.stamp.second = tzs_pkg::SEC_W'($urandom);
                    req.zone         = tzs_pkg::ZONE_W'($urandom);
                end else begin
                    // well-formed stamp biased toward day and year edges
                    case ($urandom_range(0, 7))
                        0:       yr = 100 * $urandom_range(0, 40);
                        1:       yr = 4 * $urandom_range(0, 1023);
                        2:       yr = $urandom_range(0, 1) ? 0 : 4095;
                        default: yr = $urandom_range(0, 4095);
                    endcase
                    mo  = $urandom_range(1, 12);
                    len = mon_len(mo, yr);
                    req.stamp.year  = tzs_pkg::YEAR_W'(yr);
                    req.stamp.month = tzs_pkg::MONTH_W'(mo);
                    if ($urandom_range(0, 2) == 0)
                        req.stamp.day = $urandom_range(0, 1) ? tzs_pkg::DAY_W'(1)
                                                             : tzs_pkg::DAY_W'(len);
                    else
                        req.stamp.day = tzs_pkg::DAY_W'($urandom_range(1, len));
                    req.stamp.week = tzs_pkg::WEEK_W'($urandom_range(0, 6));
                    if ($urandom_range(0, 2) == 0)
                        req.stamp.hour = $urandom_range(0, 1) ? tzs_pkg::HOUR_W'(0)
                                                              : tzs_pkg::HOUR_W'(23);
                    else
                        req.stamp.hour = tzs_pkg::HOUR_W'($urandom_range(0, 23));
                    if ($urandom_range(0, 3) == 0)
                        req.stamp.minute = $urandom_range(0, 1) ? tzs_pkg::MIN_W'(0)
                                                                : tzs_pkg::MIN_W'(59);
                    else
                        req.stamp.minute = tzs_pkg::MIN_W'($urandom_range(0, 59));
                    req.stamp.second = tzs_pkg::SEC_W'($urandom_range(0, 59));
                    req.zone = ($urandom_range(0, 6) == 0) ? tzs_pkg::ZONE_W'($urandom)
                                                           : rand_zone();
                    // broken stamp: one field pushed past its range (day: zero, or from the month's end up to 31)
                    if (kind == 1) begin
                        case ($urandom_range(0, 5))
                            0: req.stamp.month  = ($urandom_range(0, 3) == 0) ?
                                   tzs_pkg::MONTH_W'(0) :
                                   tzs_pkg::MONTH_W'($urandom_range(13, 15));
                            1: req.stamp.day    = $urandom_range(0, 1) ?
                                   tzs_pkg::DAY_W'(0) :
                                   tzs_pkg::DAY_W'($urandom_range(len, 31));
                            2: req.stamp.week   = tzs_pkg::WEEK_W'(7);
                            3: req.stamp.hour   = tzs_pkg::HOUR_W'($urandom_range(24, 31));
                            4: req.stamp.minute = tzs_pkg::MIN_W'($urandom_range(60, 63));
                            default: req.stamp.second =
                                   tzs_pkg::SEC_W'($urandom_range(60, 63));
                        endcase
                    end
                end
                offer_stamp(req, shift_stamp(req, zone_reg));
            end
        end

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        while (local_stamps_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tzs_pkg.sv
rtl/tzs_offset.sv
rtl/tzs_clock.sv
rtl/tzs_calendar.sv
rtl/timezone_datetime_shift_core.sv
dv/timezone_datetime_shift_core_tb.sv
